FILE: rtl/lqrgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lqrgs_pkg;

  localparam int StateCount = 6;
  localparam int PolyTerms  = 4;
  localparam int GainRows   = 2;
  localparam int GainCount  = StateCount * GainRows;

  // state element, gain, rounded product and row sum widths
  localparam int XW   = 33;
  localparam int GW   = 30;
  localparam int PW   = 47;
  localparam int SW   = 51;
  localparam int LIMW = 31;

  typedef logic signed [XW-1:0] state_vec_t [StateCount];

  localparam logic [7:0] REG_WHEEL_LIMIT = 8'd0;
  localparam logic [7:0] REG_LEG_LIMIT   = 8'd1;
  localparam logic [7:0] REG_POS_OFFSET  = 8'd2;
  localparam logic [7:0] REG_AIR_ENABLE  = 8'd3;

  // row 2*c + r: c0 (L), c1 (L^2), c2 (L^3), c3 (constant), Q16.16
  localparam logic signed [31:0] COEF_ROM [GainCount][PolyTerms] = '{
    '{-32'sd8263225, 32'sd13402763, -32'sd11903823, 32'sd60187},
    '{32'sd18444527, -32'sd58821341, 32'sd63920433, 32'sd1717},
    '{-32'sd862257, 32'sd79697, -32'sd345925, -32'sd3531},
    '{32'sd703208, 32'sd272504, -32'sd1798121, -32'sd66676},
    '{32'sd978500, -32'sd5084164, 32'sd6768399, -32'sd847075},
    '{32'sd21222174, -32'sd64099956, 32'sd66825414, -32'sd1923420},
    '{32'sd772186, -32'sd3181012, 32'sd3508138, -32'sd713289},
    '{32'sd14250701, -32'sd41102538, 32'sd41700748, -32'sd1514898},
    '{-32'sd4823205, 32'sd9697487, -32'sd8833114, 32'sd1844902},
    '{-32'sd7538158, 32'sd35131119, -32'sd44336473, 32'sd2509710},
    '{-32'sd815336, 32'sd1979899, -32'sd1943687, 32'sd341197},
    '{-32'sd3397457, 32'sd11426512, -32'sd12696354, 32'sd549870}
  };

endpackage
`default_nettype wire

FILE: rtl/lqrgs_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module lqrgs_lane (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [15:0]                     len,
  input  wire lqrgs_pkg::state_vec_t           x,
  input  wire logic                            air,
  output logic signed [lqrgs_pkg::SW-1:0]      wheel_sum,
  output logic signed [lqrgs_pkg::SW-1:0]      leg_sum
);
  import lqrgs_pkg::*;

  logic [15:0] len1_r, len2_r, l2_1_r, l2_2_r, l3_r;
  state_vec_t  x1_r, x2_r, x3_r, x4_r;
  logic        a1_r, a2_r, a3_r, a4_r;
  logic [31:0] sq;
  logic [32:0] sq_rnd;
  logic [32:0] cu;
  logic [32:0] cu_rnd;

  logic signed [32:0] t0_r [GainCount];
  logic signed [32:0] t1_r [GainCount];
  logic signed [32:0] t2_r [GainCount];
  logic signed [GW-1:0] g_r [GainCount];
  logic signed [PW-1:0] p_r [GainCount];

  // L^2 and L^3 stay below 2^16 for any 16-bit length
  always_comb begin
    sq     = len * len;
    sq_rnd = {1'b0, sq} + 33'd32768;
    cu     = l2_1_r * len1_r;
    cu_rnd = cu + 33'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len1_r <= len;
      l2_1_r <= sq_rnd[31:16];
      len2_r <= len1_r;
      l2_2_r <= l2_1_r;
      l3_r   <= cu_rnd[31:16];
      x1_r <= x; x2_r <= x1_r; x3_r <= x2_r; x4_r <= x3_r;
      a1_r <= air; a2_r <= a1_r; a3_r <= a2_r; a4_r <= a3_r;
    end
  end

  for (genvar k = 0; k < GainCount; k++) begin : g_gain
    logic signed [48:0] m0, m1, m2, r0, r1, r2;
    logic signed [34:0] gsum;
    logic signed [62:0] gx, gx_rnd;

    always_comb begin
      m0   = COEF_ROM[k][0] * $signed({1'b0, len2_r});
      m1   = COEF_ROM[k][1] * $signed({1'b0, l2_2_r});
      m2   = COEF_ROM[k][2] * $signed({1'b0, l3_r});
      r0   = m0 + 49'sd32768;
      r1   = m1 + 49'sd32768;
      r2   = m2 + 49'sd32768;
      gsum = 35'(COEF_ROM[k][3]) + 35'(t0_r[k]) + 35'(t1_r[k]) + 35'(t2_r[k]);
      gx     = g_r[k] * x4_r[k/GainRows];
      gx_rnd = gx + 63'sd32768;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t0_r[k] <= r0[48:16];
        t1_r[k] <= r1[48:16];
        t2_r[k] <= r2[48:16];
        g_r[k]  <= gsum[GW-1:0];
        // airborne: no wheel row, leg row keeps angle and rate terms
        if (a4_r && ((k % GainRows) == 0 || (k / GainRows) >= 2)) begin
          p_r[k] <= '0;
        end else begin
          p_r[k] <= gx_rnd[62:16];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wheel_sum <= SW'(p_r[0]) + SW'(p_r[2]) + SW'(p_r[4]) + SW'(p_r[6])
                 + SW'(p_r[8]) + SW'(p_r[10]);
      leg_sum   <= SW'(p_r[1]) + SW'(p_r[3]) + SW'(p_r[5]) + SW'(p_r[7])
                 + SW'(p_r[9]) + SW'(p_r[11]);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lqrgs_clamp.sv
`timescale 1ns / 1ps
`default_nettype none
module lqrgs_clamp (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [lqrgs_pkg::SW-1:0]   wheel_l,
  input  wire logic signed [lqrgs_pkg::SW-1:0]   wheel_r,
  input  wire logic signed [lqrgs_pkg::SW-1:0]   leg_l,
  input  wire logic signed [lqrgs_pkg::SW-1:0]   leg_r,
  input  wire logic [lqrgs_pkg::LIMW-1:0]        wheel_lim,
  input  wire logic [lqrgs_pkg::LIMW-1:0]        leg_lim,
  output logic signed [31:0]                     wheel_l_q,
  output logic signed [31:0]                     wheel_r_q,
  output logic signed [31:0]                     leg_l_q,
  output logic signed [31:0]                     leg_r_q,
  output logic                                   hit_q
);
  import lqrgs_pkg::*;

  logic signed [SW-1:0] v [4];
  logic signed [SW-1:0] lim [4];
  logic signed [31:0]   c [4];
  logic [3:0]           hit;

  always_comb begin
    v[0] = wheel_l; v[1] = wheel_r; v[2] = leg_l; v[3] = leg_r;
    lim[0] = SW'({1'b0, wheel_lim});
    lim[1] = lim[0];
    lim[2] = SW'({1'b0, leg_lim});
    lim[3] = lim[2];
    for (int i = 0; i < 4; i++) begin
      if (v[i] > lim[i]) begin
        c[i] = lim[i][31:0]; hit[i] = 1'b1;
      end else if (v[i] < -lim[i]) begin
        c[i] = -lim[i][31:0]; hit[i] = 1'b1;
      end else begin
        c[i] = v[i][31:0]; hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wheel_l_q <= c[0];
      wheel_r_q <= c[1];
      leg_l_q   <= c[2];
      leg_r_q   <= c[3];
      hit_q     <= |hit;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lqr_gain_scheduled_balance.sv
// Gain-scheduled LQR balance law for a two-legged wheeled robot, Q16.16.
// Input channel in_valid/in_ready carries one sensor sample; output channel
// out_valid/out_ready returns the four clamped torques and the clamp flag.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes limits, position offset and
// the air-detect enable; cfg_ready is always high, unknown indexes ignored.
// Write configuration only while no sample is in flight.
// Two lanes, one per leg, each evaluate the 12 gain polynomials and the
// gain-times-state products in a 6-stage pipeline; a merge stage clamps
// both legs into the output register. Throughput: one sample per cycle,
// set by the fully pipelined lanes, while out_ready does not stall the
// output. When out_ready is low with a result held, the whole pipeline
// freezes and in_ready drops; nothing is lost. Synchronous reset (rst_n low)
// empties the pipeline and restores the default register values.
`timescale 1ns / 1ps
`default_nettype none
module lqr_gain_scheduled_balance (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_leg_length_left,
  input  wire logic [15:0]        in_leg_length_right,
  input  wire logic signed [18:0] in_angle_left,
  input  wire logic signed [22:0] in_angle_rate_left,
  input  wire logic signed [18:0] in_angle_right,
  input  wire logic signed [22:0] in_angle_rate_right,
  input  wire logic signed [23:0] in_position_error,
  input  wire logic signed [20:0] in_velocity,
  input  wire logic signed [20:0] in_speed_target,
  input  wire logic signed [18:0] in_pitch,
  input  wire logic signed [22:0] in_pitch_rate,
  input  wire logic               in_off_ground,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_wheel_torque_left,
  output logic signed [31:0]      out_wheel_torque_right,
  output logic signed [31:0]      out_leg_torque_left,
  output logic signed [31:0]      out_leg_torque_right,
  output logic                    out_clamped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import lqrgs_pkg::*;

  localparam int Depth = 7;

  logic [LIMW-1:0]    wheel_lim_r, leg_lim_r;
  logic signed [31:0] pos_off_r;
  logic               air_en_r;
  logic [Depth-1:0]   v_r;
  logic               advance;
  state_vec_t         xl, xr;
  logic signed [XW-1:0] pos, vel;
  logic               air;
  logic signed [SW-1:0] wl, wr, tl, tr;

  assign cfg_ready = 1'b1;
  assign advance   = !v_r[Depth-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = v_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_lim_r <= LIMW'(163840);
      leg_lim_r   <= LIMW'(983040);
      pos_off_r   <= 32'sd19661;
      air_en_r    <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WHEEL_LIMIT: wheel_lim_r <= cfg_data[LIMW-1:0];
        REG_LEG_LIMIT:   leg_lim_r   <= cfg_data[LIMW-1:0];
        REG_POS_OFFSET:  pos_off_r   <= cfg_data;
        REG_AIR_ENABLE:  air_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (advance) begin
      v_r <= {v_r[Depth-2:0], in_valid};
    end
  end

  always_comb begin
    pos = XW'(in_position_error) - XW'(pos_off_r);
    vel = XW'(in_velocity) - XW'(in_speed_target);
    air = air_en_r && in_off_ground;
    xl[0] = XW'(in_angle_left);
    xl[1] = XW'(in_angle_rate_left);
    xr[0] = XW'(in_angle_right);
    xr[1] = XW'(in_angle_rate_right);
    xl[2] = pos; xr[2] = pos;
    xl[3] = vel; xr[3] = vel;
    xl[4] = XW'(in_pitch); xr[4] = XW'(in_pitch);
    xl[5] = XW'(in_pitch_rate); xr[5] = XW'(in_pitch_rate);
  end

  lqrgs_lane u_lane_l (
    .clk(clk), .en(advance), .len(in_leg_length_left), .x(xl), .air(air),
    .wheel_sum(wl), .leg_sum(tl)
  );

  lqrgs_lane u_lane_r (
    .clk(clk), .en(advance), .len(in_leg_length_right), .x(xr), .air(air),
    .wheel_sum(wr), .leg_sum(tr)
  );

  lqrgs_clamp u_clamp (
    .clk(clk), .en(advance),
    .wheel_l(wl), .wheel_r(wr), .leg_l(tl), .leg_r(tr),
    .wheel_lim(wheel_lim_r), .leg_lim(leg_lim_r),
    .wheel_l_q(out_wheel_torque_left), .wheel_r_q(out_wheel_torque_right),
    .leg_l_q(out_leg_torque_left), .leg_r_q(out_leg_torque_right),
    .hit_q(out_clamped)
  );

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_wheel_in_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (33'(out_wheel_torque_left) <= $signed({2'b0, wheel_lim_r}) &&
                   33'(out_wheel_torque_left) >= -$signed({2'b0, wheel_lim_r})))
    else $error("left wheel torque outside limit");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lqrgs_pkg::*;

  typedef struct {
    logic [15:0]        len_l, len_r;
    logic signed [18:0] ang_l, ang_r, pitch;
    logic signed [22:0] rate_l, rate_r, pitch_rate;
    logic signed [23:0] pos_err;
    logic signed [20:0] vel, spd;
    logic               off_gnd;
  } sample_t;

  typedef struct {
    logic signed [31:0] wl, wr, tl, tr;
    logic               clamped;
  } torques_t;

  class torque_scoreboard;
    longint   wheel_lim, leg_lim, pos_ofs;
    bit       air_en;
    torques_t due[$];
    int       errors;

    function new();
      wheel_lim = 163840;
      leg_lim   = 983040;
      pos_ofs   = 19661;
      air_en    = 1;
      errors    = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
        REG_WHEEL_LIMIT: wheel_lim = longint'({1'b0, val[30:0]});
        REG_LEG_LIMIT:   leg_lim   = longint'({1'b0, val[30:0]});
        REG_POS_OFFSET:  pos_ofs   = longint'(signed'(val));
        REG_AIR_ENABLE:  air_en    = val[0];
        default: ;
      endcase
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b + 64'sd32768) >>> 16;
    endfunction

    function void leg_law(longint len, longint x[StateCount], bit air,
                          output longint wheel, output longint leg);
      longint l2, l3, g;
      longint acc[GainRows];
      l2 = qmul(len, len);
      l3 = qmul(l2, len);
      acc[0] = 0;
      acc[1] = 0;
      for (int c = 0; c < StateCount; c++) begin
        for (int r = 0; r < GainRows; r++) begin
          g = longint'(COEF_ROM[c*GainRows+r][3]) +
              qmul(COEF_ROM[c*GainRows+r][0], len) +
              qmul(COEF_ROM[c*GainRows+r][1], l2) +
              qmul(COEF_ROM[c*GainRows+r][2], l3);
          // airborne: wheel row dropped, leg row keeps angle and angle rate terms only
          if (!(air && (r == 0 || c >= 2))) acc[r] += qmul(g, x[c]);
        end
      end
      wheel = acc[0];
      leg   = acc[1];
    endfunction

    function logic signed [31:0] clamp(longint v, longint lim, inout bit hit);
      if (v > lim) begin
        hit = 1;
        return lim[31:0];
      end
      if (v < -lim) begin
        hit = 1;
        return 32'(-lim);
      end
      return v[31:0];
    endfunction

    function void note_input(sample_t s);
      longint xl[StateCount], xr[StateCount];
      longint wl, wr, tl, tr;
      bit air, hit;
      torques_t t;
      air = air_en && s.off_gnd;
      hit = 0;
      xl[0] = s.ang_l;
      xl[1] = s.rate_l;
      xr[0] = s.ang_r;
      xr[1] = s.rate_r;
      xl[2] = longint'(s.pos_err) - pos_ofs;
      xl[3] = longint'(s.vel) - longint'(s.spd);
      xl[4] = s.pitch;
      xl[5] = s.pitch_rate;
      for (int i = 2; i < StateCount; i++) xr[i] = xl[i];
      leg_law(longint'(s.len_l), xl, air, wl, tl);
      leg_law(longint'(s.len_r), xr, air, wr, tr);
      t.wl = clamp(wl, wheel_lim, hit);
      t.wr = clamp(wr, wheel_lim, hit);
      t.tl = clamp(tl, leg_lim, hit);
      t.tr = clamp(tr, leg_lim, hit);
      t.clamped = hit;
      due.push_back(t);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(torques_t got);
      torques_t want;
      if (due.size() == 0) begin
        report("result with nothing pending", 1, 0);
        return;
      end
      want = due.pop_front();
      if (got.wl !== want.wl) report("wheel_torque_left", got.wl, want.wl);
      if (got.wr !== want.wr) report("wheel_torque_right", got.wr, want.wr);
      if (got.tl !== want.tl) report("leg_torque_left", got.tl, want.tl);
      if (got.tr !== want.tr) report("leg_torque_right", got.tr, want.tr);
      if (got.clamped !== want.clamped) report("clamped", got.clamped, want.clamped);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [15:0] in_leg_length_left = 0, in_leg_length_right = 0;
  logic signed [18:0] in_angle_left = 0, in_angle_right = 0, in_pitch = 0;
  logic signed [22:0] in_angle_rate_left = 0, in_angle_rate_right = 0, in_pitch_rate = 0;
  logic signed [23:0] in_position_error = 0;
  logic signed [20:0] in_velocity = 0, in_speed_target = 0;
  logic in_off_ground = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_wheel_torque_left, out_wheel_torque_right;
  logic signed [31:0] out_leg_torque_left, out_leg_torque_right;
  logic out_clamped;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  torque_scoreboard sb = new();
  bit calm = 0;       // no idling in the closing stretch
  bit long_hold = 0;  // receiver holds off for a long stretch
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  lqr_gain_scheduled_balance DUT (.*);

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    torques_t r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        r.wl = out_wheel_torque_left;
        r.wr = out_wheel_torque_right;
        r.tl = out_leg_torque_left;
        r.tr = out_leg_torque_right;
        r.clamped = out_clamped;
        sb.check_result(r);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("timeout");
        $display("testbench failed");
        $finish;
      end
    end
  end

  task send_sample(sample_t s);
    in_leg_length_left  <= s.len_l;
    in_leg_length_right <= s.len_r;
    in_angle_left       <= s.ang_l;
    in_angle_rate_left  <= s.rate_l;
    in_angle_right      <= s.ang_r;
    in_angle_rate_right <= s.rate_r;
    in_position_error   <= s.pos_err;
    in_velocity         <= s.vel;
    in_speed_target     <= s.spd;
    in_pitch            <= s.pitch;
    in_pitch_rate       <= s.pitch_rate;
    in_off_ground       <= s.off_gnd;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(s);
  endtask

  task drain();
    in_valid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task write_reg(logic [7:0] idx, logic [31:0] val);
    drain();
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
  endtask

  function sample_t directed_sample(int k);
    sample_t s;
    case (k % 6)
      0: s = '{default: '0};
      1: s = '{len_l: 16'hffff, len_r: 16'hffff, ang_l: 19'h3ffff, ang_r: 19'h3ffff,
               pitch: 19'h3ffff, rate_l: 23'h3fffff, rate_r: 23'h3fffff,
               pitch_rate: 23'h3fffff, pos_err: 24'h7fffff, vel: 21'hfffff,
               spd: 21'h100000, off_gnd: 0};
      2: s = '{len_l: 0, len_r: 16'hffff, ang_l: 19'h40000, ang_r: 19'h40000,
               pitch: 19'h40000, rate_l: 23'h400000, rate_r: 23'h400000,
               pitch_rate: 23'h400000, pos_err: 24'h800000, vel: 21'h100000,
               spd: 21'hfffff, off_gnd: 0};
      3: s = '{len_l: 32768, len_r: 32768, ang_l: 205887, ang_r: -205887,
               pitch: 205887, rate_l: 3276800, rate_r: -3276800, pitch_rate: 3276800,
               pos_err: 6553600, vel: 655360, spd: -655360, off_gnd: 0};
      4: s = '{len_l: 16384, len_r: 8192, ang_l: -205887, ang_r: 205887,
               pitch: -205887, rate_l: -3276800, rate_r: 3276800,
               pitch_rate: -3276800, pos_err: -6553600, vel: -655360,
               spd: 655360, off_gnd: 0};
      default: s = '{len_l: 20000, len_r: 12000, ang_l: 3000, ang_r: -2000,
               pitch: 1000, rate_l: 5000, rate_r: -7000, pitch_rate: 900,
               pos_err: 19661, vel: 1000, spd: 1000, off_gnd: 0};
    endcase
    s.off_gnd = (k >= 6);
    return s;
  endfunction

  function sample_t random_sample();
    sample_t s;
    s.len_l = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    s.len_r = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768));
    if ($urandom_range(0, 3) == 0) begin
      // raw patterns across the full field width
      s.ang_l = 19'($urandom()); s.ang_r = 19'($urandom()); s.pitch = 19'($urandom());
      s.rate_l = 23'($urandom()); s.rate_r = 23'($urandom());
      s.pitch_rate = 23'($urandom());
      s.pos_err = 24'($urandom()); s.vel = 21'($urandom()); s.spd = 21'($urandom());
    end else begin
      s.ang_l = 19'(int'($urandom_range(0, 411774)) - 205887);
      s.ang_r = 19'(int'($urandom_range(0, 411774)) - 205887);
      s.pitch = 19'(int'($urandom_range(0, 411774)) - 205887);
      s.rate_l = 23'(int'($urandom_range(0, 6553600)) - 3276800);
      s.rate_r = 23'(int'($urandom_range(0, 6553600)) - 3276800);
      s.pitch_rate = 23'(int'($urandom_range(0, 6553600)) - 3276800);
      s.pos_err = 24'(int'($urandom_range(0, 13107200)) - 6553600);
      s.vel = 21'(int'($urandom_range(0, 1310720)) - 655360);
      s.spd = 21'(int'($urandom_range(0, 1310720)) - 655360);
    end
    s.off_gnd = $urandom_range(0, 3) == 0;
    return s;
  endfunction

  task random_run(int count);
    int n;
    for (int i = 0; i < count; i++) begin
      send_sample(random_sample());
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int k = 0; k < 12; k++) send_sample(directed_sample(k));
    write_reg(REG_AIR_ENABLE, 32'd0);
    for (int k = 6; k < 12; k++) send_sample(directed_sample(k));
    write_reg(REG_WHEEL_LIMIT, 32'hffffffff);
    write_reg(REG_LEG_LIMIT, 32'h7fffffff);
    write_reg(REG_POS_OFFSET, 32'h80000000);
    write_reg(REG_AIR_ENABLE, 32'hfffffffe);
    for (int k = 0; k < 6; k++) send_sample(directed_sample(k));

    // long receiver hold-off while samples keep coming
    long_hold = 1;
    random_run(200);
    // sender pauses until everything is back
    drain();

    write_reg(REG_WHEEL_LIMIT, 32'd0);
    write_reg(REG_LEG_LIMIT, 32'd0);
    write_reg(REG_POS_OFFSET, 32'h7fffffff);
    write_reg(REG_AIR_ENABLE, 32'd1);
    random_run(250);

    write_reg(8'd4, 32'hdeadbeef);
    write_reg(8'hff, 32'd0);
    write_reg(REG_WHEEL_LIMIT, 32'd65536);
    write_reg(REG_LEG_LIMIT, 32'd327680);
    write_reg(REG_POS_OFFSET, 32'hffff0000);
    random_run(400);

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_WHEEL_LIMIT, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 600000));
      write_reg(REG_LEG_LIMIT, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3000000));
      write_reg(REG_POS_OFFSET, $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 200000));
      write_reg(REG_AIR_ENABLE, $urandom());
      random_run(220);
    end

    write_reg(REG_WHEEL_LIMIT, 32'd163840);
    write_reg(REG_LEG_LIMIT, 32'd983040);
    write_reg(REG_POS_OFFSET, 32'd19661);
    write_reg(REG_AIR_ENABLE, 32'd1);
    random_run(150);
    calm = 1;
    random_run(250);

    in_valid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule
